// ===== rtl/kfpu_pkg.sv =====
package kfpu_pkg;

  localparam int STATE_DIM = 4;
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 7;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ACC_W     = PROD_W - FRAC_BITS + 3;
  localparam int EXT_W     = DATA_W + 2;
  localparam int NUM_W     = DATA_W + 1 + FRAC_BITS;
  localparam int QUO_W     = NUM_W + 1;
  localparam int CNT_W     = $clog2(STATE_DIM + 1);

  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  localparam word_t W_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam word_t W_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_PREDICT = 2'd1;
  localparam logic [1:0] KIND_UPDATE  = 2'd2;

  localparam logic [2:0] TGT_F = 3'd0;
  localparam logic [2:0] TGT_H = 3'd1;
  localparam logic [2:0] TGT_R = 3'd2;
  localparam logic [2:0] TGT_Q = 3'd3;
  localparam logic [2:0] TGT_X = 3'd4;
  localparam logic [2:0] TGT_P = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SINGULAR = 2'd1;
  localparam logic [1:0] ST_SAT      = 2'd2;

  localparam addr_t F_BASE   = 7'd0;
  localparam addr_t P_BASE   = 7'd16;
  localparam addr_t Q_BASE   = 7'd32;
  localparam addr_t H_BASE   = 7'd48;
  localparam addr_t R_BASE   = 7'd56;
  localparam addr_t X_BASE   = 7'd60;
  localparam addr_t T1_BASE  = 7'd64;
  localparam addr_t T2_BASE  = 7'd80;
  localparam addr_t TX_BASE  = 7'd96;
  localparam addr_t Y_BASE   = 7'd100;
  localparam addr_t DET_SLOT = 7'd102;
  localparam addr_t PHT_BASE = 7'd104;
  localparam addr_t S_BASE   = 7'd112;
  localparam addr_t SI_BASE  = 7'd116;
  localparam addr_t K_BASE   = 7'd120;

  typedef struct packed {
    logic [1:0]        kind;
    logic [2:0]        target;
    logic [1:0]        row;
    logic [1:0]        col;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] meas_px;
    logic signed [DATA_W-1:0] meas_py;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] est_px;
    logic signed [DATA_W-1:0] est_py;
    logic signed [DATA_W-1:0] est_vx;
    logic signed [DATA_W-1:0] est_vy;
    logic [1:0]               status;
  } result_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOAD, S_PHASE, S_ELEM, S_TERM, S_WAIT,
    S_DSTART, S_DWAIT, S_WRITE, S_CHECK, S_DONE
  } ctrl_state_t;

  typedef enum logic [1:0] {PH_MAC, PH_DET, PH_DIV, PH_END} phase_kind_t;

  typedef enum logic [2:0] {
    POST_SAT, POST_ADD, POST_ZSUB, POST_IDSUB, POST_COPY, POST_DIV, POST_DET
  } post_t;

  typedef enum logic [1:0] {WR_ZERO, WR_LOAD, WR_POST} wr_sel_t;

  typedef struct packed {
    phase_kind_t pkind;
    addr_t       a_base;
    addr_t       b_base;
    addr_t       c_base;
    addr_t       o_base;
    cnt_t        n;
    cnt_t        m;
    cnt_t        p;
    logic        bt;
    post_t       post;
  } phase_t;

  typedef struct packed {
    logic    item_take;
    addr_t   rd_a_addr;
    addr_t   rd_b_addr;
    logic    term;
    logic    term_neg;
    logic    c_load;
    logic    acc_clr;
    logic    wr_en;
    addr_t   wr_addr;
    wr_sel_t wr_sel;
    post_t   post;
    logic    diag;
    logic    zsel;
    logic    div_start;
    logic    div_neg;
    logic    singular;
  } dp_cmd_t;

  typedef struct packed {
    logic det_zero;
    logic div_done;
  } dp_stat_t;

  localparam logic [3:0] PH_PRED = 4'd0;
  localparam logic [3:0] PH_UPD  = 4'd5;

  function automatic phase_t phase_entry(input logic [3:0] idx);
    phase_t e;
    unique case (idx)
      4'd0:  e = '{PH_MAC, F_BASE, X_BASE, X_BASE, TX_BASE,
                   CNT_W'(4), CNT_W'(4), CNT_W'(1), 1'b0, POST_SAT};
      4'd1:  e = '{PH_MAC, F_BASE, P_BASE, P_BASE, T1_BASE,
                   CNT_W'(4), CNT_W'(4), CNT_W'(4), 1'b0, POST_SAT};
      4'd2:  e = '{PH_MAC, T1_BASE, F_BASE, Q_BASE, P_BASE,
                   CNT_W'(4), CNT_W'(4), CNT_W'(4), 1'b1, POST_ADD};
      4'd3:  e = '{PH_MAC, TX_BASE, TX_BASE, TX_BASE, X_BASE,
                   CNT_W'(4), CNT_W'(0), CNT_W'(1), 1'b0, POST_COPY};
      4'd5:  e = '{PH_MAC, H_BASE, X_BASE, X_BASE, Y_BASE,
                   CNT_W'(2), CNT_W'(4), CNT_W'(1), 1'b0, POST_ZSUB};
      4'd6:  e = '{PH_MAC, P_BASE, H_BASE, P_BASE, PHT_BASE,
                   CNT_W'(4), CNT_W'(4), CNT_W'(2), 1'b1, POST_SAT};
      4'd7:  e = '{PH_MAC, H_BASE, PHT_BASE, R_BASE, S_BASE,
                   CNT_W'(2), CNT_W'(4), CNT_W'(2), 1'b0, POST_ADD};
      4'd8:  e = '{PH_DET, S_BASE, S_BASE + 7'd3, S_BASE, DET_SLOT,
                   CNT_W'(1), CNT_W'(2), CNT_W'(1), 1'b0, POST_DET};
      4'd9:  e = '{PH_DIV, S_BASE, S_BASE, S_BASE, SI_BASE,
                   CNT_W'(4), CNT_W'(0), CNT_W'(1), 1'b0, POST_DIV};
      4'd10: e = '{PH_MAC, PHT_BASE, SI_BASE, SI_BASE, K_BASE,
                   CNT_W'(4), CNT_W'(2), CNT_W'(2), 1'b0, POST_SAT};
      4'd11: e = '{PH_MAC, K_BASE, Y_BASE, X_BASE, X_BASE,
                   CNT_W'(4), CNT_W'(2), CNT_W'(1), 1'b0, POST_ADD};
      4'd12: e = '{PH_MAC, K_BASE, H_BASE, H_BASE, T1_BASE,
                   CNT_W'(4), CNT_W'(2), CNT_W'(4), 1'b0, POST_IDSUB};
      4'd13: e = '{PH_MAC, T1_BASE, P_BASE, P_BASE, T2_BASE,
                   CNT_W'(4), CNT_W'(4), CNT_W'(4), 1'b0, POST_SAT};
      4'd14: e = '{PH_MAC, T2_BASE, T2_BASE, T2_BASE, P_BASE,
                   CNT_W'(4), CNT_W'(0), CNT_W'(4), 1'b0, POST_COPY};
      default: e = '{PH_END, F_BASE, F_BASE, F_BASE, F_BASE,
                     CNT_W'(1), CNT_W'(0), CNT_W'(1), 1'b0, POST_SAT};
    endcase
    return e;
  endfunction

endpackage

// ===== rtl/kfpu_div.sv =====
module kfpu_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [kfpu_pkg::DATA_W:0]     num,
  input  kfpu_pkg::word_t                      den,
  output logic                                 done,
  output logic signed [kfpu_pkg::QUO_W-1:0]    quo
);
  import kfpu_pkg::*;

  localparam int CW = $clog2(NUM_W);

  logic              running;
  logic [CW-1:0]     cnt;
  logic [DATA_W-1:0] rem;
  logic [NUM_W-1:0]  q;
  logic [DATA_W-1:0] dmag;
  logic              neg;
  logic [DATA_W:0]   nabs;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   rem_sub;
  logic              ge;

  always_comb begin
    nabs    = num[DATA_W] ? -num : num;
    rem_sh  = {rem, q[NUM_W-1]};
    ge      = rem_sh >= {1'b0, dmag};
    rem_sub = rem_sh - {1'b0, dmag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(NUM_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q    <= {nabs, {FRAC_BITS{1'b0}}};
      rem  <= '0;
      dmag <= den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);
      neg  <= num[DATA_W] ^ den[DATA_W-1];
    end else if (running) begin
      rem <= ge ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
      q   <= {q[NUM_W-2:0], ge};
    end
  end

  assign quo = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});

endmodule

// ===== rtl/kfpu_dpath.sv =====
module kfpu_dpath (
  input  logic               clk,
  input  logic               rst,
  input  kfpu_pkg::in_item_t item,
  input  kfpu_pkg::dp_cmd_t  cmd,
  output kfpu_pkg::dp_stat_t stat,
  output kfpu_pkg::result_t  result
);
  import kfpu_pkg::*;

  localparam logic signed [PROD_W-1:0] HALF    = PROD_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [EXT_W-1:0]  ONE_EXT = EXT_W'(1) <<< FRAC_BITS;

  word_t mem [MEM_DEPTH];
  word_t rd_a, rd_b;
  word_t xreg [STATE_DIM];
  word_t value_r, z0, z1, creg, det_r;
  word_t wr_data, acc_sat, post_val;

  logic term_q1, term_q2, neg_q1, neg_q2, cload_q1, sat_flag;
  logic signed [PROD_W-1:0] prod, rnd_full;
  logic signed [ACC_W-1:0]  acc, rnd;
  logic signed [EXT_W-1:0]  ext;
  logic signed [DATA_W:0]   div_num;
  logic signed [QUO_W-1:0]  quo;
  logic                     div_done, f_acc, f_out, use_acc;
  logic [ACC_W-DATA_W:0]    hi_acc;
  logic [EXT_W-DATA_W:0]    hi_ext;
  logic [QUO_W-DATA_W:0]    hi_quo;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= wr_data;
    end
    rd_a <= mem[cmd.rd_a_addr];
    rd_b <= mem[cmd.rd_b_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      term_q1  <= 1'b0;
      term_q2  <= 1'b0;
      cload_q1 <= 1'b0;
      neg_q1   <= 1'b0;
      neg_q2   <= 1'b0;
      sat_flag <= 1'b0;
    end else begin
      term_q1  <= cmd.term;
      term_q2  <= term_q1;
      cload_q1 <= cmd.c_load;
      neg_q1   <= cmd.term_neg;
      neg_q2   <= neg_q1;
      if (cmd.item_take) begin
        sat_flag <= 1'b0;
      end else if (cmd.wr_en && cmd.wr_sel == WR_POST && (f_acc || f_out)) begin
        sat_flag <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (term_q1) begin
      prod <= rd_a * rd_b;
    end
    if (cload_q1) begin
      creg <= rd_a;
    end
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (term_q2) begin
      acc <= neg_q2 ? acc - rnd : acc + rnd;
    end
    if (cmd.item_take) begin
      value_r <= item.value;
      z0      <= item.meas_px;
      z1      <= item.meas_py;
    end
    if (cmd.wr_en && cmd.wr_sel == WR_POST && cmd.post == POST_DET) begin
      det_r <= acc_sat;
    end
    if (cmd.wr_en && cmd.wr_addr[ADDR_W-1:2] == X_BASE[ADDR_W-1:2]) begin
      xreg[cmd.wr_addr[1:0]] <= wr_data;
    end
  end

  assign rnd_full = (prod + HALF) >>> FRAC_BITS;
  assign rnd      = rnd_full[ACC_W-1:0];
  assign div_num  = cmd.div_neg ? -(DATA_W+1)'(creg) : (DATA_W+1)'(creg);

  kfpu_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (det_r),
    .done  (div_done),
    .quo   (quo)
  );

  always_comb begin
    hi_acc = acc[ACC_W-1:DATA_W-1];
    if (&hi_acc || ~|hi_acc) begin
      acc_sat = acc[DATA_W-1:0];
      f_acc   = 1'b0;
    end else begin
      acc_sat = acc[ACC_W-1] ? W_MIN : W_MAX;
      f_acc   = 1'b1;
    end

    use_acc = 1'b1;
    unique case (cmd.post)
      POST_SAT:   ext = EXT_W'(acc_sat);
      POST_ADD:   ext = EXT_W'(acc_sat) + EXT_W'(creg);
      POST_ZSUB:  ext = EXT_W'(cmd.zsel ? z1 : z0) - EXT_W'(acc_sat);
      POST_IDSUB: ext = (cmd.diag ? ONE_EXT : EXT_W'(0)) - EXT_W'(acc_sat);
      POST_COPY: begin
        ext     = EXT_W'(creg);
        use_acc = 1'b0;
      end
      POST_DIV: begin
        ext     = '0;
        use_acc = 1'b0;
      end
      POST_DET:   ext = EXT_W'(acc_sat);
      default:    ext = EXT_W'(acc_sat);
    endcase
    f_acc = f_acc && use_acc;

    hi_ext = ext[EXT_W-1:DATA_W-1];
    hi_quo = quo[QUO_W-1:DATA_W-1];
    if (cmd.post == POST_DIV) begin
      if (&hi_quo || ~|hi_quo) begin
        post_val = quo[DATA_W-1:0];
        f_out    = 1'b0;
      end else begin
        post_val = quo[QUO_W-1] ? W_MIN : W_MAX;
        f_out    = 1'b1;
      end
    end else if (&hi_ext || ~|hi_ext) begin
      post_val = ext[DATA_W-1:0];
      f_out    = 1'b0;
    end else begin
      post_val = ext[EXT_W-1] ? W_MIN : W_MAX;
      f_out    = 1'b1;
    end

    unique case (cmd.wr_sel)
      WR_ZERO: wr_data = '0;
      WR_LOAD: wr_data = value_r;
      WR_POST: wr_data = post_val;
      default: wr_data = '0;
    endcase
  end

  assign stat.det_zero = (det_r == '0);
  assign stat.div_done = div_done;

  assign result.est_px = xreg[0];
  assign result.est_py = xreg[1];
  assign result.est_vx = xreg[2];
  assign result.est_vy = xreg[3];
  assign result.status = cmd.singular ? ST_SINGULAR : (sat_flag ? ST_SAT : ST_OK);

endmodule

// ===== rtl/kfpu_ctrl.sv =====
module kfpu_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  kfpu_pkg::in_item_t item,
  input  kfpu_pkg::dp_stat_t stat,
  output logic               busy,
  output logic               done,
  output kfpu_pkg::dp_cmd_t  cmd
);
  import kfpu_pkg::*;

  ctrl_state_t state, state_next;
  addr_t       clr_cnt;
  logic [3:0]  ph;
  cnt_t        i, j, k;
  logic        wcnt;
  logic [1:0]  kind_r;
  logic [2:0]  target_r;
  logic [1:0]  row_r, col_r;
  logic        singular_r;
  phase_t      cur;
  addr_t       a_addr, b_addr, c_addr, o_addr, dc_addr, ld_addr;
  logic        ld_ok, last_elem;

  assign cur = phase_entry(ph);

  always_comb begin
    a_addr  = cur.a_base + ADDR_W'(i) * ADDR_W'(cur.m) + ADDR_W'(k);
    if (cur.pkind == PH_DET) begin
      b_addr = cur.b_base - ADDR_W'(k);
    end else if (cur.bt) begin
      b_addr = cur.b_base + ADDR_W'(j) * ADDR_W'(cur.m) + ADDR_W'(k);
    end else begin
      b_addr = cur.b_base + ADDR_W'(k) * ADDR_W'(cur.p) + ADDR_W'(j);
    end
    c_addr  = cur.c_base + ADDR_W'(i) * ADDR_W'(cur.p) + ADDR_W'(j);
    o_addr  = cur.o_base + ADDR_W'(i) * ADDR_W'(cur.p) + ADDR_W'(j);
    if (i == CNT_W'(0)) begin
      dc_addr = S_BASE + ADDR_W'(3);
    end else if (i == CNT_W'(3)) begin
      dc_addr = S_BASE;
    end else begin
      dc_addr = S_BASE + ADDR_W'(i);
    end
    last_elem = (i == cur.n - CNT_W'(1)) && (j == cur.p - CNT_W'(1));
  end

  always_comb begin
    ld_ok   = 1'b1;
    ld_addr = F_BASE + ADDR_W'({row_r, col_r});
    unique case (target_r)
      TGT_F: ld_addr = F_BASE + ADDR_W'({row_r, col_r});
      TGT_P: ld_addr = P_BASE + ADDR_W'({row_r, col_r});
      TGT_Q: ld_addr = Q_BASE + ADDR_W'({row_r, col_r});
      TGT_H: begin
        ld_ok   = !row_r[1];
        ld_addr = H_BASE + ADDR_W'({row_r[0], col_r});
      end
      TGT_R: begin
        ld_ok   = !row_r[1] && !col_r[1];
        ld_addr = R_BASE + ADDR_W'({row_r[0], col_r[0]});
      end
      TGT_X: ld_addr = X_BASE + ADDR_W'(row_r);
      default: ld_ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (clr_cnt == ADDR_W'(MEM_DEPTH - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (start) begin
          priority case (item.kind)
            KIND_LOAD:    state_next = S_LOAD;
            KIND_PREDICT: state_next = S_PHASE;
            KIND_UPDATE:  state_next = S_PHASE;
            default:      state_next = S_DONE;
          endcase
        end
      end
      S_LOAD:   state_next = S_DONE;
      S_PHASE:  state_next = (cur.pkind == PH_END) ? S_DONE : S_ELEM;
      S_ELEM:   state_next = (cur.m == CNT_W'(0)) ? S_WAIT : S_TERM;
      S_TERM:   if (k == cur.m - CNT_W'(1)) state_next = S_WAIT;
      S_WAIT:   if (wcnt) state_next = (cur.pkind == PH_DIV) ? S_DSTART : S_WRITE;
      S_DSTART: state_next = S_DWAIT;
      S_DWAIT:  if (stat.div_done) state_next = S_WRITE;
      S_WRITE: begin
        if (last_elem) begin
          state_next = (cur.pkind == PH_DET) ? S_CHECK : S_PHASE;
        end else begin
          state_next = S_ELEM;
        end
      end
      S_CHECK:  state_next = stat.det_zero ? S_DONE : S_PHASE;
      S_DONE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt    <= '0;
      ph         <= '0;
      i          <= '0;
      j          <= '0;
      k          <= '0;
      wcnt       <= 1'b0;
      kind_r     <= KIND_LOAD;
      target_r   <= TGT_F;
      row_r      <= '0;
      col_r      <= '0;
      singular_r <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: clr_cnt <= clr_cnt + ADDR_W'(1);
        S_IDLE: begin
          if (start) begin
            kind_r     <= item.kind;
            target_r   <= item.target;
            row_r      <= item.row;
            col_r      <= item.col;
            singular_r <= 1'b0;
            ph         <= (item.kind == KIND_UPDATE) ? PH_UPD : PH_PRED;
          end
        end
        S_PHASE: begin
          i <= '0;
          j <= '0;
        end
        S_ELEM: begin
          k    <= '0;
          wcnt <= 1'b0;
        end
        S_TERM: k <= k + CNT_W'(1);
        S_WAIT: wcnt <= 1'b1;
        S_WRITE: begin
          if (j == cur.p - CNT_W'(1)) begin
            j <= '0;
            if (i == cur.n - CNT_W'(1)) begin
              i  <= '0;
              ph <= ph + 4'd1;
            end else begin
              i <= i + CNT_W'(1);
            end
          end else begin
            j <= j + CNT_W'(1);
          end
        end
        S_CHECK: if (stat.det_zero) singular_r <= 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    cmd  = '0;
    busy = (state != S_IDLE);
    done = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_ZERO;
        cmd.wr_addr = clr_cnt;
      end
      S_IDLE:  cmd.item_take = start;
      S_LOAD: begin
        cmd.wr_en   = ld_ok && (kind_r == KIND_LOAD);
        cmd.wr_sel  = WR_LOAD;
        cmd.wr_addr = ld_addr;
      end
      S_ELEM: begin
        cmd.acc_clr   = 1'b1;
        cmd.c_load    = 1'b1;
        cmd.rd_a_addr = (cur.pkind == PH_DIV) ? dc_addr : c_addr;
      end
      S_TERM: begin
        cmd.term      = 1'b1;
        cmd.rd_a_addr = a_addr;
        cmd.rd_b_addr = b_addr;
        cmd.term_neg  = (cur.pkind == PH_DET) && (k == CNT_W'(1));
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_neg   = (i == CNT_W'(1)) || (i == CNT_W'(2));
      end
      S_WRITE: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_POST;
        cmd.wr_addr = o_addr;
        cmd.post    = cur.post;
        cmd.diag    = (i == j);
        cmd.zsel    = i[0];
      end
      S_DONE: begin
        done         = 1'b1;
        cmd.singular = singular_r;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/kalman_filter_predict_update.sv =====
// Channel   Signals                  Transaction
// input     start, busy, item        start high and busy low at a rising edge
// result    done, result             done high for one cycle, taken at its end
//
// Each matrix element is computed on the single multiply-accumulate path
// (m terms, one per cycle, plus the read, product and write steps); an update
// includes four restoring divisions.
// Reset: a clearing pass zeroes all 128 words of the matrix memory; busy is high.
// Stalls: one transaction at a time; busy stays high until done is strobed.
module kalman_filter_predict_update (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  kfpu_pkg::in_item_t item,
  output logic               busy,
  output logic               done,
  output kfpu_pkg::result_t  result
);
  import kfpu_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  kfpu_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .stat  (stat),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  kfpu_dpath u_dpath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .stat   (stat),
    .result (result)
  );

endmodule

// ===== tb/sv/kalman_filter_predict_update_tb.sv =====
module kalman_filter_predict_update_tb;
  import kfpu_pkg::*;

  localparam int  N_RANDOM = 1350;
  localparam longint Q_ONE = longint'(1) <<< FRAC_BITS;

  typedef word_t mat16_t [16];

  typedef struct {
    in_item_t it;
    bit       typed;
    result_t  want;
  } dir_row_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  in_item_t item = '0;
  logic     busy;
  logic     done;
  result_t  result;

  kalman_filter_predict_update u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always #5 clk = ~clk;

  mat16_t xv, pcov, fmat, hmat, rmat, qmat;
  bit     clamp_seen;

  result_t  est_q [$];
  dir_row_t dir_tab [$];
  int       n_mismatch, n_results, n_loads, n_predicts, n_updates, n_other;
  int       n_singular, n_saturated;

  function automatic word_t sat32(longint v);
    if (v > longint'(W_MAX)) begin
      clamp_seen = 1'b1;
      return W_MAX;
    end
    if (v < longint'(W_MIN)) begin
      clamp_seen = 1'b1;
      return W_MIN;
    end
    return word_t'(v);
  endfunction

  function automatic longint qmul(word_t a, word_t b);
    longint pr;
    pr = longint'(a) * longint'(b);
    return (pr + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic void mat_mul(input mat16_t a, input int n, input int m,
                                  input mat16_t b, input bit bt, input int p,
                                  output mat16_t o);
    longint acc;
    o = '{default: '0};
    for (int i = 0; i < n; i++)
      for (int j = 0; j < p; j++) begin
        acc = 0;
        for (int k = 0; k < m; k++)
          acc += qmul(a[i*m+k], bt ? b[j*m+k] : b[k*p+j]);
        o[i*p+j] = sat32(acc);
      end
  endfunction

  function automatic bit filter_update(word_t zx, word_t zy);
    mat16_t hx, y, s, si, pht, kg, ky, kh, np;
    word_t  det;
    longint num;
    mat_mul(hmat, 2, 4, xv, 1'b0, 1, hx);
    y = '{default: '0};
    y[0] = sat32(longint'(zx) - longint'(hx[0]));
    y[1] = sat32(longint'(zy) - longint'(hx[1]));
    mat_mul(pcov, 4, 4, hmat, 1'b1, 2, pht);
    mat_mul(hmat, 2, 4, pht, 1'b0, 2, s);
    for (int i = 0; i < 4; i++) s[i] = sat32(longint'(s[i]) + longint'(rmat[i]));
    det = sat32(qmul(s[0], s[3]) - qmul(s[1], s[2]));
    if (det == 0) return 1'b0;
    si = '{default: '0};
    for (int i = 0; i < 4; i++) begin
      case (i)
        0:       num = longint'(s[3]);
        3:       num = longint'(s[0]);
        default: num = -longint'(s[i]);
      endcase
      si[i] = sat32((num * Q_ONE) / longint'(det));
    end
    mat_mul(pht, 4, 2, si, 1'b0, 2, kg);
    mat_mul(kg, 4, 2, y, 1'b0, 1, ky);
    for (int i = 0; i < 4; i++) xv[i] = sat32(longint'(xv[i]) + longint'(ky[i]));
    mat_mul(kg, 4, 2, hmat, 1'b0, 4, kh);
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        kh[i*4+j] = sat32((i == j ? Q_ONE : 0) - longint'(kh[i*4+j]));
    mat_mul(kh, 4, 4, pcov, 1'b0, 4, np);
    pcov = np;
    return 1'b1;
  endfunction

  function automatic result_t filter_step(in_item_t it);
    result_t r;
    mat16_t  fx, fp, fpf;
    r = '0;
    clamp_seen = 1'b0;
    case (it.kind)
      KIND_LOAD: begin
        case (it.target)
          TGT_F: fmat[it.row*4+it.col] = it.value;
          TGT_H: if (it.row < 2) hmat[it.row*4+it.col] = it.value;
          TGT_R: if (it.row < 2 && it.col < 2) rmat[it.row*2+it.col] = it.value;
          TGT_Q: qmat[it.row*4+it.col] = it.value;
          TGT_X: xv[it.row] = it.value;
          TGT_P: pcov[it.row*4+it.col] = it.value;
          default: ;
        endcase
      end
      KIND_PREDICT: begin
        mat_mul(fmat, 4, 4, xv, 1'b0, 1, fx);
        mat_mul(fmat, 4, 4, pcov, 1'b0, 4, fp);
        mat_mul(fp, 4, 4, fmat, 1'b1, 4, fpf);
        for (int i = 0; i < 4; i++) xv[i] = fx[i];
        for (int i = 0; i < 16; i++) pcov[i] = sat32(longint'(fpf[i]) + longint'(qmat[i]));
        r.status = clamp_seen ? ST_SAT : ST_OK;
      end
      KIND_UPDATE: begin
        if (!filter_update(it.meas_px, it.meas_py)) r.status = ST_SINGULAR;
        else r.status = clamp_seen ? ST_SAT : ST_OK;
      end
      default: ;
    endcase
    r.est_px = xv[0];
    r.est_py = xv[1];
    r.est_vx = xv[2];
    r.est_vy = xv[3];
    return r;
  endfunction

  function automatic in_item_t mk(logic [1:0] k, logic [2:0] t, logic [1:0] r,
                                  logic [1:0] c, word_t v, word_t px, word_t py);
    in_item_t it;
    it.kind = k; it.target = t; it.row = r; it.col = c;
    it.value = v; it.meas_px = px; it.meas_py = py;
    return it;
  endfunction

  function automatic result_t rs(word_t a, word_t b, word_t c, word_t d, logic [1:0] st);
    result_t r;
    r.est_px = a; r.est_py = b; r.est_vx = c; r.est_vy = d; r.status = st;
    return r;
  endfunction

  function automatic word_t rnd_q(int mag);
    return word_t'(int'($urandom_range(0, 2 * mag)) - mag);
  endfunction

  function automatic word_t rnd_pos(int lo, int hi);
    return word_t'($urandom_range(lo, hi));
  endfunction

  task automatic send(in_item_t it, bit typed, result_t want);
    int      gap;
    result_t r;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    r = filter_step(it);
    est_q.push_back(typed ? want : r);
    case (it.kind)
      KIND_LOAD:    n_loads++;
      KIND_PREDICT: n_predicts++;
      KIND_UPDATE:  n_updates++;
      default:      n_other++;
    endcase
  endtask

  task automatic send_chk(in_item_t it);
    send(it, 1'b0, '0);
  endtask

  task automatic load_track(bit broken);
    int dt;
    dt = $urandom_range(1 << 12, 1 << 17);
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        if (broken && $urandom_range(0, 3) == 0) continue;
        if (r == c)
          send_chk(mk(KIND_LOAD, TGT_F, 2'(r), 2'(c), rnd_pos(60000, 70000), 0, 0));
        else if (c == r + 2)
          send_chk(mk(KIND_LOAD, TGT_F, 2'(r), 2'(c), word_t'(dt), 0, 0));
        else
          send_chk(mk(KIND_LOAD, TGT_F, 2'(r), 2'(c), rnd_q(2000), 0, 0));
      end
    for (int r = 0; r < 2; r++)
      for (int c = 0; c < 4; c++)
        if (!(broken && $urandom_range(0, 3) == 0))
          send_chk(mk(KIND_LOAD, TGT_H, 2'(r), 2'(c),
                      (r == c) ? rnd_pos(50000, 80000) : rnd_q(3000), 0, 0));
    for (int r = 0; r < 2; r++)
      for (int c = 0; c < 2; c++)
        send_chk(mk(KIND_LOAD, TGT_R, 2'(r), 2'(c),
                    (r == c) ? rnd_pos(1000, 200000) : rnd_q(500), 0, 0));
    for (int i = 0; i < 4; i++) begin
      send_chk(mk(KIND_LOAD, TGT_Q, 2'(i), 2'(i), rnd_pos(0, 5000), 0, 0));
      send_chk(mk(KIND_LOAD, TGT_P, 2'(i), 2'(i), rnd_pos(1000, 300000), 0, 0));
      send_chk(mk(KIND_LOAD, TGT_X, 2'(i), 2'($urandom), rnd_q(1 << 22), 0, 0));
    end
  endtask

  task automatic run_track(int steps);
    for (int s = 0; s < steps; s++) begin
      if ($urandom_range(0, 1))
        send_chk(mk(KIND_PREDICT, 3'($urandom), 2'($urandom), 2'($urandom),
                    $urandom, $urandom, $urandom));
      else
        send_chk(mk(KIND_UPDATE, 3'($urandom), 2'($urandom), 2'($urandom), $urandom,
                    ($urandom_range(0, 9) == 0) ? word_t'($urandom) : rnd_q(1 << 23),
                    ($urandom_range(0, 9) == 0) ? word_t'($urandom) : rnd_q(1 << 23)));
    end
  endtask

  task automatic report(string fld, logic [31:0] e, logic [31:0] a);
    n_mismatch++;
    if (n_mismatch <= 10)
      $display("mismatch on result %0d, %s: expected %h actual %h", n_results, fld, e, a);
  endtask

  always @(posedge clk) begin
    result_t e;
    if (!rst && done) begin
      if (est_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result %p", result);
      end else begin
        e = est_q.pop_front();
        if (result.est_px !== e.est_px) report("est_px", e.est_px, result.est_px);
        if (result.est_py !== e.est_py) report("est_py", e.est_py, result.est_py);
        if (result.est_vx !== e.est_vx) report("est_vx", e.est_vx, result.est_vx);
        if (result.est_vy !== e.est_vy) report("est_vy", e.est_vy, result.est_vy);
        if (result.status !== e.status)
          report("status", 32'(e.status), 32'(result.status));
      end
      if (result.status == ST_SINGULAR) n_singular++;
      if (result.status == ST_SAT) n_saturated++;
      n_results++;
    end
  end

  initial begin
    #(64'd60_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int        sent;
    xv = '{default: '0}; pcov = xv; fmat = xv; hmat = xv; rmat = xv; qmat = xv;
    dir_tab.push_back('{mk(KIND_PREDICT, 0, 0, 0, 0, 0, 0), 1, rs(0, 0, 0, 0, ST_OK)});
    dir_tab.push_back('{mk(KIND_UPDATE, 0, 0, 0, 0, W_MAX, W_MIN), 1,
                        rs(0, 0, 0, 0, ST_SINGULAR)});
    dir_tab.push_back('{mk(2'd3, 7, 3, 3, W_MAX, W_MAX, W_MAX), 1, rs(0, 0, 0, 0, ST_OK)});
    dir_tab.push_back('{mk(KIND_LOAD, TGT_X, 0, 3, W_MAX, 0, 0), 1,
                        rs(W_MAX, 0, 0, 0, ST_OK)});
    dir_tab.push_back('{mk(KIND_LOAD, TGT_X, 3, 0, W_MIN, 0, 0), 1,
                        rs(W_MAX, 0, 0, W_MIN, ST_OK)});
    dir_tab.push_back('{mk(KIND_LOAD, 3'd6, 0, 0, 32'h1234, 0, 0), 1,
                        rs(W_MAX, 0, 0, W_MIN, ST_OK)});
    dir_tab.push_back('{mk(KIND_LOAD, 3'd7, 1, 1, 32'h1234, 0, 0), 1,
                        rs(W_MAX, 0, 0, W_MIN, ST_OK)});
    dir_tab.push_back('{mk(KIND_LOAD, TGT_H, 2, 0, W_MAX, 0, 0), 1,
                        rs(W_MAX, 0, 0, W_MIN, ST_OK)});
    dir_tab.push_back('{mk(KIND_LOAD, TGT_R, 0, 2, W_MAX, 0, 0), 1,
                        rs(W_MAX, 0, 0, W_MIN, ST_OK)});
    for (int i = 0; i < 4; i++)
      dir_tab.push_back('{mk(KIND_LOAD, TGT_F, 2'(i), 2'(i), word_t'(Q_ONE), 0, 0), 0, '0});
    dir_tab.push_back('{mk(KIND_LOAD, TGT_F, 0, 2, word_t'(Q_ONE), 0, 0), 0, '0});
    dir_tab.push_back('{mk(KIND_PREDICT, 0, 0, 0, 0, 0, 0), 0, '0});
    dir_tab.push_back('{mk(KIND_LOAD, TGT_H, 0, 0, word_t'(Q_ONE), 0, 0), 0, '0});
    dir_tab.push_back('{mk(KIND_LOAD, TGT_H, 1, 1, word_t'(Q_ONE), 0, 0), 0, '0});
    dir_tab.push_back('{mk(KIND_LOAD, TGT_R, 0, 0, word_t'(Q_ONE), 0, 0), 0, '0});
    dir_tab.push_back('{mk(KIND_LOAD, TGT_R, 1, 1, word_t'(Q_ONE), 0, 0), 0, '0});
    dir_tab.push_back('{mk(KIND_LOAD, TGT_P, 1, 1, word_t'(Q_ONE), 0, 0), 0, '0});
    dir_tab.push_back('{mk(KIND_UPDATE, 0, 0, 0, 0, W_MIN, W_MAX), 0, '0});
    dir_tab.push_back('{mk(KIND_LOAD, TGT_Q, 3, 3, W_MAX, 0, 0), 0, '0});
    dir_tab.push_back('{mk(KIND_LOAD, TGT_F, 3, 3, W_MIN, 0, 0), 0, '0});
    dir_tab.push_back('{mk(KIND_PREDICT, 0, 0, 0, 0, 0, 0), 0, '0});
    dir_tab.push_back('{mk(KIND_UPDATE, 0, 0, 0, 0, 32'sh0001_0000, 32'sh0002_0000), 0, '0});

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_tab[i]) send(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].want);

    sent = 0;
    while (sent < N_RANDOM) begin
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(5, 20)) begin
          send_chk(mk(2'($urandom), 3'($urandom), 2'($urandom), 2'($urandom),
                      $urandom, $urandom, $urandom));
        end
      end else begin
        load_track($urandom_range(0, 4) == 0);
        run_track($urandom_range(8, 30));
      end
      sent = n_loads + n_predicts + n_updates + n_other;
    end
    start <= 1'b0;

    while (est_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d loads, %0d predicts, %0d updates, %0d unused kinds; %0d results",
             n_loads, n_predicts, n_updates, n_other, n_results);
    $display("results flagged singular %0d, saturated %0d; mismatches %0d",
             n_singular, n_saturated, n_mismatch);
    if (n_mismatch == 0 && est_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/kfpu_pkg.sv
rtl/kfpu_div.sv
rtl/kfpu_dpath.sv
rtl/kfpu_ctrl.sv
rtl/kalman_filter_predict_update.sv
tb/sv/kalman_filter_predict_update_tb.sv
